// ===== rtl/plpp_pkg.sv =====
// Shared types and constants of the peer-list packet parser.
package plpp_pkg;

	// Packet status codes carried by a status record
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_TYPE  = 3'd1,
		ST_TRUNC = 3'd2,
		ST_LEN   = 3'd3,
		ST_PORT  = 3'd4,
		ST_TRAIL = 3'd5
	} status_t;

	// Record kinds on the result channel
	localparam logic KIND_PEER   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Required value of the per-peer address length byte
	localparam logic [7:0] IPV4_LEN = 8'd4;

	// Last address byte position within a peer
	localparam logic [1:0] ADDR_LAST = 2'd3;

	// Outcome of one input byte: an optional peer record, then an optional status record
	typedef struct packed {
		logic        has_peer;
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] idx;
		logic        has_status;
		status_t     status;
	} entry_t;

endpackage

// ===== rtl/peer_list_packet_parser_unit.sv =====
// Top level of the byte-serial peer-list packet parser.
//
// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   data_byte, end_of_packet
// out      source     out_valid / out_stall record_kind, ip_addr, port_num,
//                                           peer_index, status, last
// cfg      sink       cfg_valid / cfg_ready cfg_data (expected_type)
//
// One byte is taken per cycle while in_stall is low. The parser state
// advances at the edge that accepts a byte, and the byte's outcome (a peer
// record, a status record, or both) enters a FIFO_DEPTH-entry result queue in
// the same edge; a queue entry that carries both records shows its peer record
// first, then its status record; in_stall rises only while the queue is full.
// Reset clears the parser state, the queue and expected_type; cfg_ready is
// always high.
module peer_list_packet_parser_unit #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        record_kind,
	output logic [31:0] ip_addr,
	output logic [15:0] port_num,
	output logic [15:0] peer_index,
	output logic [2:0]  status,
	output logic        last,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import plpp_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

	// Parser phases, one per field of the packet, then PH_DONE
	typedef enum logic [2:0] {
		PH_TYPE,
		PH_COUNT_HI,
		PH_COUNT_LO,
		PH_LEN,
		PH_ADDR,
		PH_PORT_HI,
		PH_PORT_LO,
		PH_DONE
	} phase_t;

	// Configuration register
	logic [7:0] expected_type_q;

	// Parser state
	phase_t      phase_q, phase_nx;
	logic [1:0]  byte_cnt_q, byte_cnt_nx;
	logic [15:0] remain_q, remain_nx;
	logic [15:0] next_idx_q, next_idx_nx;
	logic [31:0] addr_q, addr_nx;
	logic [7:0]  high_q, high_nx;
	status_t     err_q, err_nx;

	// Result queue
	entry_t           fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             half_q;

	logic       in_fire;
	logic       push, pop;
	entry_t     new_entry, head;
	logic       show_peer;
	logic [15:0] port_val;
	status_t    end_status;

	assign cfg_ready = 1'b1;
	assign in_stall  = (count_q == CNT_FULL);
	assign in_fire   = in_valid && !in_stall;

	// Next parser state and the byte's outcome
	always_comb begin
		phase_nx    = phase_q;
		byte_cnt_nx = byte_cnt_q;
		remain_nx   = remain_q;
		next_idx_nx = next_idx_q;
		addr_nx     = addr_q;
		high_nx     = high_q;
		err_nx      = err_q;
		port_val    = {high_q, data_byte};
		end_status  = ST_OK;

		new_entry            = '0;
		new_entry.addr       = addr_q;
		new_entry.port       = port_val;
		new_entry.idx        = next_idx_q;
		new_entry.status     = ST_OK;

		if (err_q == ST_OK) begin
			case (phase_q)
				PH_TYPE: begin
					if (data_byte != expected_type_q) err_nx = ST_TYPE;
					else phase_nx = PH_COUNT_HI;
				end
				PH_COUNT_HI: begin
					high_nx  = data_byte;
					phase_nx = PH_COUNT_LO;
				end
				PH_COUNT_LO: begin
					remain_nx   = port_val;
					next_idx_nx = '0;
					phase_nx    = (port_val == 16'd0) ? PH_DONE : PH_LEN;
				end
				PH_LEN: begin
					// check the length before any address byte is taken
					if (data_byte != IPV4_LEN) begin
						err_nx = ST_LEN;
					end else begin
						byte_cnt_nx = '0;
						addr_nx     = '0;
						phase_nx    = PH_ADDR;
					end
				end
				PH_ADDR: begin
					addr_nx = {addr_q[23:0], data_byte};
					if (byte_cnt_q == ADDR_LAST) begin
						byte_cnt_nx = '0;
						phase_nx    = PH_PORT_HI;
					end else begin
						byte_cnt_nx = byte_cnt_q + 2'd1;
					end
				end
				PH_PORT_HI: begin
					high_nx  = data_byte;
					phase_nx = PH_PORT_LO;
				end
				PH_PORT_LO: begin
					if (port_val == 16'd0) begin
						err_nx = ST_PORT;
					end else begin
						new_entry.has_peer = 1'b1;
						next_idx_nx        = next_idx_q + 16'd1;
						remain_nx          = remain_q - 16'd1;
						phase_nx           = (remain_q == 16'd1) ? PH_DONE : PH_LEN;
					end
				end
				default: begin
					err_nx = ST_TRAIL;
				end
			endcase
		end

		if (end_of_packet) begin
			// report the first error, else whether the packet was complete
			if (err_nx != ST_OK) end_status = err_nx;
			else if (phase_nx != PH_DONE) end_status = ST_TRUNC;
			else end_status = ST_OK;
			new_entry.has_status = 1'b1;
			new_entry.status     = end_status;
			// drop all packet state
			phase_nx    = PH_TYPE;
			byte_cnt_nx = '0;
			remain_nx   = '0;
			next_idx_nx = '0;
			addr_nx     = '0;
			high_nx     = '0;
			err_nx      = ST_OK;
		end
	end

	assign push = in_fire && (new_entry.has_peer || new_entry.has_status);

	// Output side: a head entry shows its peer record first, then its status record
	assign head      = fifo_q[rd_ptr_q];
	assign out_valid = (count_q != '0);
	assign show_peer = head.has_peer && !half_q;
	assign pop       = out_valid && !out_stall && (!show_peer || !head.has_status);

	assign record_kind = show_peer ? KIND_PEER : KIND_STATUS;
	assign ip_addr     = show_peer ? head.addr : 32'd0;
	assign port_num    = show_peer ? head.port : 16'd0;
	assign peer_index  = show_peer ? head.idx : 16'd0;
	assign status      = show_peer ? ST_OK : head.status;
	assign last        = show_peer ? !head.has_status : 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_type_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			expected_type_q <= cfg_data;
		end
	end

	// Parser state: advance only on an accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			byte_cnt_q <= '0;
			remain_q   <= '0;
			next_idx_q <= '0;
			addr_q     <= '0;
			high_q     <= '0;
			err_q      <= ST_OK;
		end else if (in_fire) begin
			phase_q    <= phase_nx;
			byte_cnt_q <= byte_cnt_nx;
			remain_q   <= remain_nx;
			next_idx_q <= next_idx_nx;
			addr_q     <= addr_nx;
			high_q     <= high_nx;
			err_q      <= err_nx;
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end

	// Queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			half_q   <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				half_q   <= 1'b0;
			end else if (out_valid && !out_stall && show_peer) begin
				// peer record taken, status record of the same entry follows
				half_q <= 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/plpp_checker.sv =====
// Port-level checks of the peer-list packet parser and their binding.
module plpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        record_kind,
	input logic [31:0] ip_addr,
	input logic [15:0] port_num,
	input logic [15:0] peer_index,
	input logic [2:0]  status,
	input logic        last
);
	import plpp_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ip_addr) && $stable(status)
			&& $stable(record_kind) && $stable(peer_index))
		else $error("stalled result changed");

	// a status record always closes the results of its byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_STATUS |-> last)
		else $error("status record not last");

	// a peer record carries ok status and a nonzero port
	a_peer_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_PEER |-> status == ST_OK && port_num != 16'd0)
		else $error("bad peer record");

	// a status record leaves the peer fields clear
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_STATUS |->
			ip_addr == 32'd0 && port_num == 16'd0 && peer_index == 16'd0)
		else $error("status record with peer fields");

	// a peer record that is not last is followed by its status record
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && record_kind == KIND_PEER && !last |=>
			out_valid && record_kind == KIND_STATUS)
		else $error("peer record not followed by status");

endmodule

bind peer_list_packet_parser_unit plpp_checker u_plpp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.record_kind (record_kind),
	.ip_addr     (ip_addr),
	.port_num    (port_num),
	.peer_index  (peer_index),
	.status      (status),
	.last        (last)
);
